@@ hw/rtl/etfp_pkg.sv @@
// Shared types, widths and constants for the escape-time fractal pixel unit.
// Holds the sequencer state type, configuration indexes and the palette function.
// No dependencies.
package etfp_pkg;

  localparam int DATA_W    = 32;
  localparam int LIM_W     = 10;
  localparam int NUM_W     = 18;
  localparam int QUO_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 16;

  localparam logic [DATA_W-1:0] CENTER_REAL_RST = -32'sd199620367;
  localparam logic [DATA_W-1:0] CENTER_IMAG_RST = 32'd35386746;
  localparam logic [DATA_W-1:0] PIXEL_STEP_RST  = 32'd2684354;
  localparam logic [LIM_W-1:0]  ITER_LIMIT_RST  = 10'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_REAL = 2'd0,
    CFG_CENTER_IMAG = 2'd1,
    CFG_PIXEL_STEP  = 2'd2,
    CFG_ITER_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MCR,
    ST_MCI,
    ST_PREP,
    ST_MY2,
    ST_MX1,
    ST_BULB,
    ST_SQ,
    ST_QX,
    ST_MQ,
    ST_CARD,
    ST_IT_A,
    ST_IT_B,
    ST_IT_C,
    ST_IT_D,
    ST_DIVW
  } state_t;

  // Gradient palette, packed as RGB565. Index zero is black.
  function automatic logic [COLOR_W-1:0] palette(input logic [QUO_W-1:0] idx);
    logic [QUO_W-1:0] g;
    g = (idx + {idx[QUO_W-3:0], 2'b00}) ^ {idx[QUO_W-2:0], 1'b0};
    if (idx == '0) begin
      return '0;
    end
    return {idx[7:3], g[7:2], ~idx[7:3]};
  endfunction

endpackage

@@ hw/rtl/escape_time_fractal_pixel_unit.sv @@
// Escape-time fractal pixel unit: one pixel request in, one color and iteration count out.
// A bulb or cardioid hit finishes early; otherwise each iteration runs through states IT_A to
// IT_D on the shared multiplier until the limit is used up or the point escapes. A new request
// is taken only in idle, after the result. Reset (rst_n, synchronous) restores register defaults.
// Each result is strobed on out_valid for one cycle; the receiver cannot stall it.
module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
  parameter int SCREEN_W  = 256,
  parameter int SCREEN_H  = 256,
  parameter int FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_pixel_x,
  input  logic [7:0]           in_pixel_y,
  output logic                 out_valid,
  output logic [COLOR_W-1:0]   out_pixel_color,
  output logic [LIM_W-1:0]     out_iterations_done,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  // Fixed-point constants. ONE and FOUR are formed on 64 bits and cut to 32, so a
  // large fraction width wraps the value four exactly as the arithmetic does.
  localparam logic [DATA_W-1:0] ONE     = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] FOUR    = DATA_W'(64'd4 << FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_16  = DATA_W'($signed(ONE) >>> 4);
  localparam logic [DATA_W-1:0] QUARTER = DATA_W'($signed(ONE) >>> 2);
  localparam logic [DATA_W-1:0] HALF_W  = DATA_W'(SCREEN_W / 2);
  localparam logic [DATA_W-1:0] HALF_H  = DATA_W'(SCREEN_H / 2);

  // Configuration registers.
  logic [DATA_W-1:0] ctr_re_r;
  logic [DATA_W-1:0] ctr_im_r;
  logic [DATA_W-1:0] step_r;
  logic [LIM_W-1:0]  lim_r;

  // Sequencer and datapath registers.
  state_t            state_r;
  state_t            state_nxt;
  logic [7:0]        px_r;
  logic [7:0]        py_r;
  logic [DATA_W-1:0] cr_r;
  logic [DATA_W-1:0] ci_r;
  logic [DATA_W-1:0] y2_r;
  logic [DATA_W-1:0] t_r;
  logic [DATA_W-1:0] xm_r;
  logic [DATA_W-1:0] zr_r;
  logic [DATA_W-1:0] zi_r;
  logic [DATA_W-1:0] zr2_r;
  logic [LIM_W-1:0]  it_r;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [LIM_W-1:0]   out_it_r;

  // Shared multiplier and divider hookup.
  logic [DATA_W-1:0]  mul_a;
  logic [DATA_W-1:0]  mul_b;
  logic signed [63:0] prod;
  logic [DATA_W-1:0]  fm;
  logic [DATA_W-1:0]  plo;
  logic               div_go;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [NUM_W-1:0]   div_num;

  // Decisions taken in the current state.
  logic               hit_bulb;
  logic               hit_card;
  logic               at_limit;
  logic               escaped;
  logic               fin;
  logic [COLOR_W-1:0] fin_color;
  logic [LIM_W-1:0]   fin_it;
  logic [DATA_W-1:0]  y2_q;

  // The fixed-point product is the floor of the full product shifted by the
  // fraction width, cut to 32 bits. The pixel offset uses the low 32 bits.
  assign fm   = prod[FRAC_BITS +: DATA_W];
  assign plo  = prod[DATA_W-1:0];
  assign y2_q = DATA_W'($signed(y2_r) >>> 2);

  // Period-2 bulb test: (x+1)^2 + y^2 <= 1/16.
  assign hit_bulb = ($signed(fm + y2_r) <= $signed(ONE_16));
  // Cardioid test: q*(q + x - 1/4) <= y^2/4.
  assign hit_card = ($signed(fm) <= $signed(y2_q));
  assign at_limit = (it_r >= lim_r);
  // Escape test: |z|^2 > 4, with the sum wrapped to 32 bits.
  assign escaped  = !($signed(zr2_r + fm) <= $signed(FOUR));

  // The palette index is it*255/limit; it*255 is formed as it*256 - it.
  assign div_num = NUM_W'({it_r, 8'h00}) - NUM_W'(it_r);

  etfp_mul u_mul (
    .clk  (clk),
    .a    ($signed(mul_a)),
    .b    ($signed(mul_b)),
    .prod (prod)
  );

  etfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (lim_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next-state logic. The setup runs two offset products, then the interior
  // tests, then states IT_A to IT_D for each iteration of z = z*z + c, and a divider wait on escape.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MCR;
        end
      end
      ST_MCR:  state_nxt = ST_MCI;
      ST_MCI:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MY2;
      ST_MY2:  state_nxt = ST_MX1;
      ST_MX1:  state_nxt = ST_BULB;
      ST_BULB: state_nxt = hit_bulb ? ST_IDLE : ST_SQ;
      ST_SQ:   state_nxt = ST_QX;
      ST_QX:   state_nxt = ST_MQ;
      ST_MQ:   state_nxt = ST_CARD;
      ST_CARD: state_nxt = hit_card ? ST_IDLE : ST_IT_A;
      ST_IT_A: state_nxt = at_limit ? ST_IDLE : ST_IT_B;
      ST_IT_B: state_nxt = ST_IT_C;
      ST_IT_C: state_nxt = escaped ? ST_DIVW : ST_IT_D;
      ST_IT_D: state_nxt = ST_IT_A;
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output logic: multiplier operands, divider launch and the finishing result.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_go    = 1'b0;
    fin       = 1'b0;
    fin_color = '0;
    fin_it    = '0;
    unique case (state_r)
      ST_MCR: begin
        mul_a = {24'h000000, px_r} - HALF_W;
        mul_b = step_r;
      end
      ST_MCI: begin
        mul_a = {24'h000000, py_r} - HALF_H;
        mul_b = step_r;
      end
      ST_MY2: begin
        mul_a = ci_r;
        mul_b = ci_r;
      end
      ST_MX1: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      ST_BULB: begin
        mul_a = xm_r;
        mul_b = xm_r;
        fin   = hit_bulb;
      end
      ST_MQ: begin
        mul_a = t_r;
        mul_b = xm_r;
      end
      ST_CARD: begin
        fin = hit_card;
      end
      ST_IT_A: begin
        mul_a  = zr_r;
        mul_b  = zr_r;
        fin    = at_limit;
        fin_it = it_r;
      end
      ST_IT_B: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      ST_IT_C: begin
        mul_a  = zr_r;
        mul_b  = zi_r;
        div_go = escaped;
      end
      ST_DIVW: begin
        fin       = div_done;
        fin_color = palette(div_quo);
        fin_it    = it_r;
      end
      default: begin
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ctr_re_r    <= CENTER_REAL_RST;
      ctr_im_r    <= CENTER_IMAG_RST;
      step_r      <= PIXEL_STEP_RST;
      lim_r       <= ITER_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CENTER_REAL: ctr_re_r <= cfg_data;
          CFG_CENTER_IMAG: ctr_im_r <= cfg_data;
          CFG_PIXEL_STEP:  step_r   <= cfg_data;
          CFG_ITER_LIMIT:  lim_r    <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers. Each state captures the product issued in the state
  // before it; all sums wrap to 32 bits.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          px_r <= in_pixel_x;
          py_r <= in_pixel_y;
        end
      end
      ST_MCI: begin
        cr_r <= ctr_re_r + plo;
      end
      ST_PREP: begin
        ci_r <= ctr_im_r + plo;
        t_r  <= cr_r + ONE;
        xm_r <= cr_r - QUARTER;
      end
      ST_MX1: begin
        y2_r <= fm;
      end
      ST_SQ: begin
        t_r <= fm + y2_r;
      end
      ST_QX: begin
        xm_r <= t_r + xm_r;
      end
      ST_CARD: begin
        zr_r <= '0;
        zi_r <= '0;
        it_r <= '0;
      end
      ST_IT_B: begin
        zr2_r <= fm;
      end
      ST_IT_C: begin
        zr2_r <= zr2_r - fm;
      end
      ST_IT_D: begin
        zr_r <= zr2_r + cr_r;
        zi_r <= {fm[DATA_W-2:0], 1'b0} + ci_r;
        it_r <= it_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (fin) begin
      out_color_r <= {fin_color[7:0], fin_color[15:8]};
      out_it_r    <= fin_it;
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_pixel_color     = out_color_r;
  assign out_iterations_done = out_it_r;

endmodule

@@ hw/rtl/etfp_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
// No package dependencies.
module etfp_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

@@ hw/rtl/etfp_div.sv @@
// Restoring divider for the palette index, one quotient bit per cycle.
// Depends on etfp_pkg for widths. The quotient must fit in QUO_W bits.
module etfp_div import etfp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [LIM_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsr_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic             ge;

  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num;
      dsr_r <= NUM_W'(den) << (QUO_W - 1);
      cnt_r <= '1;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dsr_r <= dsr_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
